/* design/psg_pkg.sv */
// Shared payload, command and status types for the permutation step generator.
package psg_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic DIR_LEFT  = 1'b1;
  localparam logic DIR_RIGHT = 1'b0;

  localparam logic [3:0] COUNT_RESET = 4'd8;

  typedef struct packed {
    logic        opcode;
    logic [2:0]  load_position;
    logic [15:0] load_value;
  } in_t;

  typedef struct packed {
    logic [15:0] out_value;
    logic [2:0]  out_position;
    logic        last_of_run;
    logic        final_permutation;
  } out_t;

  typedef struct packed {
    logic load;
    logic step_start;
    logic scan_rd;
    logic scan_ev;
    logic scan_end;
    logic emit_rd;
    logic emit_wr;
    logic swap_a;
    logic swap_b;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic at_last;
    logic found;
    logic out_free;
  } status_t;

endpackage

/* design/permutation_step_generator.sv */
// Top level of the permutation step generator: controller plus datapath.
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_stall    psg_pkg::in_t  (load or step)
//   out       output     out_valid / out_stall  psg_pkg::out_t (one position)
//   cfg       input      cfg_write              cfg_data = element_count
//
// A load transaction completes in the cycle it is accepted. A step over n active
// elements runs a mobility scan (skipped once done) and then an emit pass, each
// element costing a read and a compare on the single read port of the element
// store, then swaps the picked pair through its write port if one was mobile.
// Reset is synchronous: all directions point left, done clears, count is 8.
// A stalled output holds the emit pass at the current element. in_stall is high
// after an accepted step until its swap is written, or its last emit if none moves.
module permutation_step_generator #(
  parameter int MAX_ELEMENTS = 8,
  parameter int VALUE_WIDTH  = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic [3:0]    cfg_data,
  input  logic          in_valid,
  output logic          in_stall,
  input  psg_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output psg_pkg::out_t out_data
);
  import psg_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequence the phases; accept a new transaction only while idle.
  psg_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .in_stall  (in_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Hold the elements, their marks and the result register.
  psg_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* design/psg_datapath.sv */
// Datapath: element store, direction marks, scan registers and result register.
module psg_datapath #(
  parameter int MAX_ELEMENTS = 8,
  parameter int VALUE_WIDTH  = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic [3:0]      cfg_data,
  input  psg_pkg::in_t    in_data,
  input  psg_pkg::cmd_t   cmd,
  output psg_pkg::status_t status,
  output logic            out_valid,
  input  logic            out_stall,
  output psg_pkg::out_t   out_data
);
  import psg_pkg::*;

  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

  logic [VALUE_WIDTH-1:0] mem [MAX_ELEMENTS];
  logic [VALUE_WIDTH-1:0] rd_data;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;

  logic [3:0]             element_count;
  logic [MAX_ELEMENTS-1:0] dirs;
  logic                   done;
  logic                   found;
  logic [IDX_W-1:0]       idx;
  logic [IDX_W-1:0]       best_idx;
  logic [IDX_W-1:0]       dest_idx;
  logic [VALUE_WIDTH-1:0] best_val;
  logic [VALUE_WIDTH-1:0] dest_val;
  logic [VALUE_WIDTH-1:0] p1;
  logic [VALUE_WIDTH-1:0] p2;

  logic [CNT_W-1:0]       n_active;
  logic [CNT_W-1:0]       n_minus1;
  logic [IDX_W-1:0]       last_idx;
  logic [31:0]            load_pos_wide;
  logic [IDX_W-1:0]       load_idx;
  logic                   load_ok;
  logic [31:0]            load_val_wide;
  logic [31:0]            rd_wide;
  logic [31:0]            idx_wide;

  logic [IDX_W-1:0]       ev_j;
  logic                   ev_has;
  logic                   mob;
  logic                   take;

  // Clamp the element count into 1..MAX_ELEMENTS.
  always_comb begin
    priority if (element_count == 4'd0) begin
      n_active = CNT_W'(1);
    end else if (32'(element_count) > MAX_ELEMENTS) begin
      n_active = CNT_W'(MAX_ELEMENTS);
    end else begin
      n_active = CNT_W'(element_count);
    end
    n_minus1 = n_active - CNT_W'(1);
    last_idx = n_minus1[IDX_W-1:0];
  end

  assign load_pos_wide = 32'(in_data.load_position);
  assign load_idx      = load_pos_wide[IDX_W-1:0];
  assign load_ok       = load_pos_wide < MAX_ELEMENTS;
  assign load_val_wide = 32'(in_data.load_value);
  assign rd_wide       = 32'(rd_data);
  assign idx_wide      = 32'(idx);

  // Mobility test of one element at each scan_ev and at scan_end: p1 holds the
  // candidate, p2 its left neighbor, rd_data its right neighbor.
  always_comb begin
    ev_j   = idx - IDX_W'(1);
    ev_has = cmd.scan_end || (cmd.scan_ev && idx != '0);
    if (dirs[ev_j] == DIR_LEFT) begin
      mob = ev_has && ev_j != '0 && p2 < p1;
    end else begin
      mob = ev_has && !cmd.scan_end && rd_data < p1;
    end
    take = mob && (!found || p1 > best_val);
  end

  // Single read port, single write port.
  always_comb begin
    rd_en   = cmd.scan_rd || cmd.emit_rd;
    rd_addr = idx;
    wr_en   = 1'b0;
    wr_addr = load_idx;
    wr_data = load_val_wide[VALUE_WIDTH-1:0];
    priority if (cmd.load) begin
      wr_en = load_ok;
    end else if (cmd.swap_a) begin
      wr_en   = 1'b1;
      wr_addr = dest_idx;
      wr_data = best_val;
    end else if (cmd.swap_b) begin
      wr_en   = 1'b1;
      wr_addr = best_idx;
      wr_data = dest_val;
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= COUNT_RESET;
      dirs          <= '1;
      done          <= 1'b0;
      found         <= 1'b0;
      idx           <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        element_count <= cfg_data;
      end
      if (cmd.load) begin
        done <= 1'b0;
        if (load_ok) begin
          dirs[load_idx] <= DIR_LEFT;
        end
      end
      if (cmd.step_start) begin
        idx   <= '0;
        found <= 1'b0;
      end
      if (cmd.scan_ev) begin
        idx <= idx + IDX_W'(1);
      end
      if (cmd.scan_end) begin
        idx <= '0;
      end
      if (take) begin
        found <= 1'b1;
      end
      if (cmd.emit_wr) begin
        idx <= idx + IDX_W'(1);
        if (found && rd_data > best_val) begin
          dirs[idx] <= ~dirs[idx];
        end
        if (idx == last_idx && !found) begin
          done <= 1'b1;
        end
      end
      if (cmd.swap_a) begin
        dirs[dest_idx] <= dirs[best_idx];
        dirs[best_idx] <= dirs[dest_idx];
      end
      if (cmd.emit_wr) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Scan window and pick registers, plus the result payload.
  always_ff @(posedge clk) begin
    if (cmd.scan_ev) begin
      p2 <= p1;
      p1 <= rd_data;
    end
    if (take) begin
      best_idx <= ev_j;
      best_val <= p1;
      if (dirs[ev_j] == DIR_LEFT) begin
        dest_idx <= ev_j - IDX_W'(1);
        dest_val <= p2;
      end else begin
        dest_idx <= ev_j + IDX_W'(1);
        dest_val <= rd_data;
      end
    end
    if (cmd.emit_wr) begin
      out_data.out_value         <= rd_wide[15:0];
      out_data.out_position      <= idx_wide[2:0];
      out_data.last_of_run       <= idx == last_idx;
      out_data.final_permutation <= !found;
    end
  end

  assign status.done     = done;
  assign status.at_last  = idx == last_idx;
  assign status.found    = found;
  assign status.out_free = !out_valid || !out_stall;

endmodule

/* design/psg_controller.sv */
// Controller: sequences load, scan, emit and swap phases of each transaction.
module psg_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_opcode,
  output logic             in_stall,
  input  psg_pkg::status_t status,
  output psg_pkg::cmd_t    cmd
);
  import psg_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SCAN_RD  = 8'b0000_0010,
    S_SCAN_EV  = 8'b0000_0100,
    S_SCAN_END = 8'b0000_1000,
    S_EMIT_RD  = 8'b0001_0000,
    S_EMIT_WR  = 8'b0010_0000,
    S_SWAP_A   = 8'b0100_0000,
    S_SWAP_B   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = state != S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.step_start = 1'b1;
            state_next     = status.done ? S_EMIT_RD : S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_next  = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        cmd.scan_ev = 1'b1;
        state_next  = status.at_last ? S_SCAN_END : S_SCAN_RD;
      end
      S_SCAN_END: begin
        cmd.scan_end = 1'b1;
        state_next   = S_EMIT_RD;
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_next  = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        if (status.out_free) begin
          cmd.emit_wr = 1'b1;
          if (!status.at_last) begin
            state_next = S_EMIT_RD;
          end else if (status.found) begin
            state_next = S_SWAP_A;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_SWAP_A: begin
        cmd.swap_a = 1'b1;
        state_next = S_SWAP_B;
      end
      S_SWAP_B: begin
        cmd.swap_b = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* tb/tb_permutation_step_generator.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the permutation step generator.
module tb_permutation_step_generator;
  import psg_pkg::*;

  // Cycles to let pass after the last emitted value before the block counts as idle.
  localparam int SETTLE_CYCLES = 48;
  localparam int ELEMS         = 8;
  localparam int PHASE_ITEMS   = 36;

  logic  clk;
  logic  rst;
  logic  cfg_write;
  logic  [3:0] cfg_data;
  logic  in_valid;
  logic  in_stall;
  in_t   in_data;
  logic  out_valid;
  logic  out_stall = 1'b0;
  out_t  out_data;

  permutation_step_generator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // One row of the directed table: either a count write or a transaction.
  // A nonzero typed_n means the emitted arrangement is typed in by hand
  // (at most two values) instead of coming from the predictor.
  typedef struct {
    bit          is_cfg;
    logic [3:0]  count;
    in_t         item;
    int          typed_n;
    logic [15:0] t0;
    logic [15:0] t1;
    bit          t_final;
  } stim_row_t;

  // Predictor state: arrangement, direction marks, done mark, element count.
  logic [15:0] perm_vals [ELEMS];
  logic        perm_dirs [ELEMS];
  bit          perm_done;
  logic [3:0]  perm_count;

  out_t queued_emits [$];
  int   mismatch_count = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #10ms;
    $display("tb_permutation_step_generator failed");
    $finish;
  end

  // Map the register value onto the number of live elements: zero counts as
  // one, anything above the store depth counts as the full store.
  function automatic int live_count();
    if (perm_count == 4'd0) return 1;
    if (perm_count > 4'(ELEMS)) return ELEMS;
    return int'(perm_count);
  endfunction

  // Apply one transaction to the predictor. For a step, queue the emitted
  // arrangement when keep is set, then move the largest mobile element and
  // flip the marks of every larger element.
  function automatic void advance_permutation(input in_t item, input bit keep);
    int          n;
    int          i;
    int          pick;
    int          dest;
    bit          found;
    bit          mob;
    logic [15:0] moved;
    logic [15:0] tv;
    logic        td;
    out_t        r;
    if (item.opcode == OP_LOAD) begin
      perm_vals[item.load_position] = item.load_value;
      perm_dirs[item.load_position] = DIR_LEFT;
      perm_done = 1'b0;
      return;
    end
    n = live_count();
    found = 1'b0;
    pick = 0;
    if (!perm_done) begin
      for (i = 0; i < n; i++) begin
        if (perm_dirs[i] == DIR_LEFT)
          mob = (i > 0) && (perm_vals[i-1] < perm_vals[i]);
        else
          mob = (i + 1 < n) && (perm_vals[i+1] < perm_vals[i]);
        // Strict compare: on equal values the lower position keeps the pick.
        if (mob && (!found || perm_vals[i] > perm_vals[pick])) begin
          pick = i;
          found = 1'b1;
        end
      end
    end
    for (i = 0; i < n; i++) begin
      r.out_value         = perm_vals[i];
      r.out_position      = 3'(i);
      r.last_of_run       = (i == n - 1);
      r.final_permutation = !found;
      if (keep) queued_emits.push_back(r);
    end
    if (!found) begin
      perm_done = 1'b1;
      return;
    end
    dest  = (perm_dirs[pick] == DIR_LEFT) ? pick - 1 : pick + 1;
    moved = perm_vals[pick];
    tv    = perm_vals[dest];
    td    = perm_dirs[dest];
    perm_vals[dest] = perm_vals[pick];
    perm_dirs[dest] = perm_dirs[pick];
    perm_vals[pick] = tv;
    perm_dirs[pick] = td;
    for (i = 0; i < n; i++) begin
      if (perm_vals[i] > moved) perm_dirs[i] = ~perm_dirs[i];
    end
  endfunction

  function automatic in_t load_item(input int pos, input logic [15:0] val);
    in_t it;
    it.opcode        = OP_LOAD;
    it.load_position = 3'(pos);
    it.load_value    = val;
    return it;
  endfunction

  // Fill the unused fields of a step with noise: the block must ignore them.
  function automatic in_t step_item();
    in_t it;
    it.opcode        = OP_STEP;
    it.load_position = 3'($urandom_range(0, 7));
    it.load_value    = 16'($urandom);
    return it;
  endfunction

  function automatic stim_row_t cfg_row(input logic [3:0] v);
    stim_row_t row;
    row = '{1'b1, v, '0, 0, 16'h0, 16'h0, 1'b0};
    return row;
  endfunction

  function automatic stim_row_t item_row(input in_t it);
    stim_row_t row;
    row = '{1'b0, 4'd0, it, 0, 16'h0, 16'h0, 1'b0};
    return row;
  endfunction

  function automatic stim_row_t typed_step(input int n, input logic [15:0] v0,
                                           input logic [15:0] v1, input bit fin);
    stim_row_t row;
    row = '{1'b0, 4'd0, step_item(), n, v0, v1, fin};
    return row;
  endfunction

  // Present one transaction after a random gap and hold it until accepted,
  // then update the predictor. Drive valid once per edge so a back-to-back
  // transaction never sees a low and a high in the same time step.
  task automatic send_item(input in_t item, input bit keep);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_permutation(item, keep);
  endtask

  // Write element_count only while the block is idle: drain every queued
  // value, then let a load that emits nothing finish as well.
  task automatic write_count(input logic [3:0] v);
    in_valid <= 1'b0;
    while (queued_emits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    perm_count = v;
  endtask

  task automatic report_mismatch(input out_t want, input out_t got, input bit orphan);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      if (orphan)
        $display("%0t: unexpected value %h at position %0d (last %b final %b)",
                 $realtime, got.out_value, got.out_position, got.last_of_run,
                 got.final_permutation);
      else
        $display("%0t: expected value %h pos %0d last %b final %b, got %h %0d %b %b",
                 $realtime, want.out_value, want.out_position, want.last_of_run,
                 want.final_permutation, got.out_value, got.out_position,
                 got.last_of_run, got.final_permutation);
    end
  endtask

  // Output side: check each accepted transaction against the oldest queued
  // value, then pick the stall for the next edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (queued_emits.size() == 0)
        report_mismatch(out_data, out_data, 1'b1);
      else if (out_data !== queued_emits[0])
        report_mismatch(queued_emits.pop_front(), out_data, 1'b0);
      else
        void'(queued_emits.pop_front());
    end
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  initial begin
    stim_row_t   rows [];
    out_t        typed;
    int          k;
    int          j;
    int          n;
    int          phase;
    int          phase_items;
    int          style;
    int          base;
    int          stride;
    int          steps;
    logic [15:0] val;

    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    for (k = 0; k < ELEMS; k++) begin
      perm_vals[k] = '0;
      perm_dirs[k] = DIR_LEFT;
    end
    perm_done  = 1'b0;
    perm_count = COUNT_RESET;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Every position gets loaded before a step can read it.
    rows = '{
      item_row(load_item(0, 16'hFFFF)),
      cfg_row(4'd1),
      // a single element is never mobile: final on the first step
      typed_step(1, 16'hFFFF, 16'h0, 1'b1),
      // zero counts as one element; the block is already done
      cfg_row(4'd0),
      typed_step(1, 16'hFFFF, 16'h0, 1'b1),
      item_row(load_item(0, 16'h0005)),
      item_row(load_item(1, 16'h0009)),
      cfg_row(4'd2),
      typed_step(2, 16'h0005, 16'h0009, 1'b0),
      typed_step(2, 16'h0009, 16'h0005, 1'b1),
      // step while done: same arrangement again, still final
      typed_step(2, 16'h0009, 16'h0005, 1'b1),
      // two equal largest mobile values: the lower position must move
      item_row(load_item(0, 16'h0001)),
      item_row(load_item(1, 16'h0007)),
      item_row(load_item(2, 16'h0002)),
      item_row(load_item(3, 16'h0007)),
      cfg_row(4'd4),
      item_row(step_item()),
      item_row(step_item()),
      item_row(step_item()),
      // field extremes over the whole store
      item_row(load_item(0, 16'h0000)),
      item_row(load_item(1, 16'hFFFF)),
      item_row(load_item(2, 16'h8000)),
      item_row(load_item(3, 16'h0001)),
      item_row(load_item(4, 16'h7FFF)),
      item_row(load_item(5, 16'h1234)),
      item_row(load_item(6, 16'hAAAA)),
      item_row(load_item(7, 16'h5555)),
      // counts above the store depth clamp to the full store
      cfg_row(4'd15),
      item_row(step_item()),
      item_row(step_item()),
      cfg_row(4'd8)
    };

    foreach (rows[k]) begin
      if (rows[k].is_cfg) begin
        write_count(rows[k].count);
      end else begin
        send_item(rows[k].item, rows[k].typed_n == 0);
        for (j = 0; j < rows[k].typed_n; j++) begin
          typed.out_value         = (j == 0) ? rows[k].t0 : rows[k].t1;
          typed.out_position      = 3'(j);
          typed.last_of_run       = (j == rows[k].typed_n - 1);
          typed.final_permutation = rows[k].t_final;
          queued_emits.push_back(typed);
        end
      end
    end

    // Random part: each segment picks a count, loads the live positions with
    // a ramp, random or small-valued arrangement and then walks the permutation
    // sequence, with an occasional stray load that changes one value and clears done.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 76;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 76;
        end
        default: begin
          send_idle_pct  = 14;
          recv_stall_pct = 14;
        end
      endcase
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        write_count(4'($urandom_range(0, 15)));
        n      = live_count();
        style  = $urandom_range(0, 3);
        base   = $urandom_range(0, 255);
        stride = $urandom_range(1, 8000);
        for (j = 0; j < n; j++) begin
          case (style)
            0:       val = 16'(base + j * stride);
            1:       val = 16'($urandom);
            2:       val = 16'($urandom_range(0, 3));
            default: val = 16'(16'hFFFF - base - j * stride);
          endcase
          send_item(load_item(j, val), 1'b1);
          phase_items++;
        end
        steps = $urandom_range(2, 24);
        for (j = 0; j < steps; j++) begin
          if ($urandom_range(0, 9) == 0)
            send_item(load_item($urandom_range(0, 7), 16'($urandom)), 1'b1);
          else
            send_item(step_item(), 1'b1);
          phase_items++;
        end
      end
    end

    // Drain: drop valid, wait for every queued value, then watch for strays.
    in_valid <= 1'b0;
    while (queued_emits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && queued_emits.size() == 0)
      $display("tb_permutation_step_generator passed");
    else
      $display("tb_permutation_step_generator failed");
    $finish;
  end

endmodule
